@@ rtl/sss_pkg.sv @@
// shared constants, codes and transaction types for the sparse sor sweep block
package sss_pkg;

  localparam int ROW_MAX   = 64;
  localparam int ENTRY_MAX = 1024;
  localparam int ROW_AW    = $clog2(ROW_MAX);
  localparam int ROW_CW    = $clog2(ROW_MAX + 1);
  localparam int ENTRY_AW  = $clog2(ENTRY_MAX);
  localparam int ENTRY_CW  = $clog2(ENTRY_MAX + 1);

  localparam int CFG_W  = 18;
  localparam int CFG_IW = 2;

  localparam logic [2:0] ACT_ENTRY = 3'd0;
  localparam logic [2:0] ACT_ROW   = 3'd1;
  localparam logic [2:0] ACT_RHS   = 3'd2;
  localparam logic [2:0] ACT_SOL   = 3'd3;
  localparam logic [2:0] ACT_RUN   = 3'd4;
  localparam logic [2:0] ACT_READ  = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_CONV   = 2'd1;
  localparam logic [1:0] ST_NOCONV = 2'd2;
  localparam logic [1:0] ST_DIAG   = 2'd3;

  localparam logic [CFG_IW-1:0] CFG_OMEGA = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_TOL   = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_ROWS  = 2'd2;

  localparam logic [17:0] OMEGA_LIMIT = 18'd131072;

  typedef struct packed {
    logic [2:0]         action;
    logic [9:0]         slot;
    logic [5:0]         column;
    logic [10:0]        row_pointer;
    logic signed [31:0] value;
  } sss_req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
  } sss_rsp_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } sss_div_req_t;

endpackage

@@ rtl/sss_ram.sv @@
// generic single-write, single-read ram with registered read data
module sss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/sss_mul.sv @@
// shared signed 33x33 multiplier with registered product
module sss_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

@@ rtl/sss_div.sv @@
// bit-serial restoring divider for (num * 2^16) / den, truncating, saturated
module sss_div import sss_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  sss_div_req_t       req,
  output logic               busy,
  output logic               done,
  output logic signed [31:0] quo
);

  localparam int DW    = 48;
  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    dvd;
  logic [32:0]      rem;
  logic [31:0]      dsr;
  logic             neg;
  logic [CNT_W-1:0] cnt;
  logic [31:0]      num_mag;
  logic [31:0]      den_mag;
  logic [32:0]      rem_sh;
  logic             ge;

  always_comb begin
    num_mag = req.num[31] ? 32'(-req.num) : req.num;
    den_mag = req.den[31] ? 32'(-req.den) : req.den;
    rem_sh  = {rem[31:0], dvd[DW-1]};
    ge      = rem_sh >= {1'b0, dsr};
    // sign and clamp the quotient magnitude
    if (neg) begin
      if (dvd > DW'(32'h8000_0000)) quo = 32'sh8000_0000;
      else                          quo = 32'(-dvd);
    end else begin
      if (dvd > DW'(32'h7fff_ffff)) quo = 32'sh7fff_ffff;
      else                          quo = dvd[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        dvd  <= {num_mag, 16'b0};
        dsr  <= den_mag;
        rem  <= '0;
        neg  <= req.num[31] ^ req.den[31];
        cnt  <= CNT_W'(DW);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? (rem_sh - {1'b0, dsr}) : rem_sh;
        dvd <= {dvd[DW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/sparse_sor_sweep.sv @@
// top level: command decode, sweep sequencer, stores and convergence test
//
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------
//  command  | start high, busy low     | request (sss_req_t)
//  result   | done, one cycle, no hold | result  (sss_rsp_t)
//  config   | cfg_we                   | cfg_index, cfg_data
//
// a load command is answered in the cycle after it is accepted, a solution
// read passes through S_READ first; result and done are registered together
// when the work is done; a run walks every stored entry of each row twice
// (sweep, then residual pass), using the one multiplier and the stores with
// a single read port; each sweep row also waits on the bit-serial divider
// rst is synchronous, clears the sequencer and strobes and loads the config
// defaults; stores hold whatever was written; the receiver cannot stall,
// busy holds off commands
module sparse_sor_sweep import sss_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  sss_req_t          request,
  output logic              busy,
  output logic              done,
  output sss_rsp_t          result,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_READ, S_RLO, S_RHI, S_RHIW, S_EADDR, S_EDATA, S_MUL, S_ACC,
    S_REND, S_RB, S_DIV, S_QM, S_QA, S_TB, S_TR, S_TBB, S_T2, S_T2W,
    S_B1, S_B2, S_B3
  } state_t;

  localparam logic signed [65:0] W_MAX = 66'sd2147483647;
  localparam logic signed [65:0] W_MIN = -66'sd2147483648;

  // saturate a wide signed value to q16.16
  function automatic logic signed [31:0] sat_w(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > W_MAX)      r = 32'sh7fff_ffff;
    else if (v < W_MIN) r = 32'sh8000_0000;
    else                r = 32'(v);
    return r;
  endfunction

  // product back to q16.16, floor rounding
  function automatic logic signed [31:0] qmul(input logic signed [65:0] p);
    return sat_w(p >>> 16);
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat_w(66'(a) + 66'(b));
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat_w(66'(a) - 66'(b));
  endfunction

  function automatic logic [ENTRY_CW-1:0] clamp_ptr(input logic [10:0] p);
    return (32'(p) > ENTRY_MAX) ? ENTRY_CW'(ENTRY_MAX) : ENTRY_CW'(p);
  endfunction

  // configuration registers
  logic [17:0] omega;
  logic [16:0] tolerance;
  logic [6:0]  row_count;

  state_t               state;
  logic [ROW_CW-1:0]    n;
  logic [ROW_CW-1:0]    i;
  logic [17:0]          om;
  logic                 pass;
  logic [ENTRY_CW-1:0]  k;
  logic [ENTRY_CW-1:0]  hi;
  logic signed [31:0]   sigma;
  logic signed [31:0]   diag;
  logic                 have_diag;
  logic signed [31:0]   ev;
  logic signed [31:0]   xi;
  logic signed [31:0]   qv;
  logic signed [31:0]   bv;
  logic [63:0]          sum_r;
  logic [63:0]          sum_b;
  logic [33:0]          t2;
  logic [31:0]          p1_hi;
  logic                 rd_ok;

  logic                 accept;
  logic [37:0]          entry_q;
  logic [10:0]          row_q;
  logic [31:0]          rhs_q;
  logic [31:0]          sol_q;
  logic [5:0]           e_col;
  logic signed [31:0]   e_val;
  logic [ROW_CW-1:0]    row_raddr;
  logic                 sol_we;
  logic [ROW_AW-1:0]    sol_waddr;
  logic [ROW_AW-1:0]    sol_raddr;
  logic signed [31:0]   sol_wdata;
  logic signed [31:0]   new_x;
  logic signed [31:0]   r_now;
  logic signed [32:0]   mul_a;
  logic signed [32:0]   mul_b;
  logic signed [65:0]   mul_p;
  logic [64:0]          add_r;
  logic [64:0]          add_b;
  logic [64:0]          add_bound;
  logic [66:0]          bound_sum;
  logic [63:0]          bound;
  sss_div_req_t         div_req;
  logic                 div_busy;
  logic                 div_done;
  logic signed [31:0]   div_quo;

  assign accept = start && !busy;
  assign busy   = state != S_IDLE;
  assign e_col  = entry_q[37:32];
  assign e_val  = entry_q[31:0];
  assign new_x  = qadd(xi, qmul(mul_p));
  assign r_now  = qsub(rhs_q, sigma);

  // squared-norm sums saturate at the top of 64 bits
  assign add_r     = {1'b0, sum_r} + {1'b0, mul_p[63:0]};
  assign add_b     = {1'b0, sum_b} + {1'b0, mul_p[63:0]};
  assign add_bound = {1'b0, mul_p[63:0]} + 65'(p1_hi);
  // the two top bits of tol^2 scale sum_b directly
  assign bound_sum = 67'(add_bound) + 67'({sum_b, 1'b0} & {65{t2[33]}}) +
                     67'(sum_b & {64{t2[32]}});
  assign bound     = (|bound_sum[66:64]) ? '1 : bound_sum[63:0];

  assign div_req.start = state == S_RB;
  assign div_req.num   = r_now;
  assign div_req.den   = diag;

  always_comb begin
    row_raddr = (state == S_RHI) ? ROW_CW'(i + 1'b1) : i;
    sol_we    = (state == S_QA) ||
                (accept && request.action == ACT_SOL && 32'(request.slot) < ROW_MAX);
    sol_waddr = (state == S_QA) ? ROW_AW'(i) : ROW_AW'(request.slot);
    sol_wdata = (state == S_QA) ? new_x : request.value;
    unique case (state)
      S_EDATA: sol_raddr = ROW_AW'(e_col);
      S_REND:  sol_raddr = ROW_AW'(i);
      default: sol_raddr = ROW_AW'(request.slot);
    endcase
  end

  // operand select for the shared multiplier
  always_comb begin
    unique case (state)
      S_MUL: begin
        mul_a = 33'(ev);
        mul_b = 33'(signed'(sol_q));
      end
      S_QM: begin
        mul_a = $signed({15'b0, om});
        mul_b = 33'(qsub(qv, xi));
      end
      S_TB: begin
        mul_a = 33'(r_now);
        mul_b = 33'(r_now);
      end
      S_TR: begin
        mul_a = 33'(bv);
        mul_b = 33'(bv);
      end
      S_T2: begin
        mul_a = $signed({16'b0, tolerance});
        mul_b = $signed({16'b0, tolerance});
      end
      S_B1: begin
        mul_a = $signed({1'b0, t2[31:0]});
        mul_b = $signed({1'b0, sum_b[31:0]});
      end
      S_B2: begin
        mul_a = $signed({1'b0, t2[31:0]});
        mul_b = $signed({1'b0, sum_b[63:32]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  sss_ram #(.WIDTH(38), .DEPTH(ENTRY_MAX)) u_entry (
    .clk   (clk),
    .we    (accept && request.action == ACT_ENTRY && 32'(request.slot) < ENTRY_MAX),
    .waddr (ENTRY_AW'(request.slot)),
    .wdata ({request.column, request.value}),
    .raddr (ENTRY_AW'(k)),
    .rdata (entry_q)
  );

  sss_ram #(.WIDTH(11), .DEPTH(ROW_MAX + 1)) u_row (
    .clk   (clk),
    .we    (accept && request.action == ACT_ROW && 32'(request.slot) <= ROW_MAX),
    .waddr (ROW_CW'(request.slot)),
    .wdata (request.row_pointer),
    .raddr (row_raddr),
    .rdata (row_q)
  );

  sss_ram #(.WIDTH(32), .DEPTH(ROW_MAX)) u_rhs (
    .clk   (clk),
    .we    (accept && request.action == ACT_RHS && 32'(request.slot) < ROW_MAX),
    .waddr (ROW_AW'(request.slot)),
    .wdata (request.value),
    .raddr (ROW_AW'(i)),
    .rdata (rhs_q)
  );

  sss_ram #(.WIDTH(32), .DEPTH(ROW_MAX)) u_sol (
    .clk   (clk),
    .we    (sol_we),
    .waddr (sol_waddr),
    .wdata (sol_wdata),
    .raddr (sol_raddr),
    .rdata (sol_q)
  );

  sss_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  sss_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .busy (div_busy),
    .done (div_done),
    .quo  (div_quo)
  );

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      omega     <= 18'd65536;
      tolerance <= 17'd66;
      row_count <= 7'd64;
    end else if (cfg_we) begin
      if (cfg_index == CFG_OMEGA) omega     <= cfg_data[17:0];
      if (cfg_index == CFG_TOL)   tolerance <= cfg_data[16:0];
      if (cfg_index == CFG_ROWS)  row_count <= cfg_data[6:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (request.action == ACT_RUN) begin
              n     <= (32'(row_count) > ROW_MAX) ? ROW_CW'(ROW_MAX) : ROW_CW'(row_count);
              om    <= (omega > OMEGA_LIMIT) ? OMEGA_LIMIT : omega;
              i     <= '0;
              pass  <= 1'b0;
              sum_r <= '0;
              sum_b <= '0;
              state <= S_RLO;
            end else if (request.action == ACT_READ) begin
              rd_ok <= 32'(request.slot) < ROW_MAX;
              state <= S_READ;
            end else begin
              result <= '{read_value: '0, status: ST_OK};
              done   <= 1'b1;
            end
          end
        end
        S_READ: begin
          result <= '{read_value: (rd_ok ? sol_q : '0), status: ST_OK};
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        // row bounds come out of the row store one per cycle
        S_RLO: begin
          if (i == n) begin
            if (!pass) begin
              pass <= 1'b1;
              i    <= '0;
            end else begin
              state <= S_T2;
            end
          end else begin
            state <= S_RHI;
          end
        end
        S_RHI: begin
          k     <= clamp_ptr(row_q);
          state <= S_RHIW;
        end
        S_RHIW: begin
          hi        <= clamp_ptr(row_q);
          sigma     <= '0;
          have_diag <= 1'b0;
          state     <= S_EADDR;
        end
        S_EADDR: begin
          state <= (k >= hi) ? S_REND : S_EDATA;
        end
        S_EDATA: begin
          ev <= e_val;
          if (32'(e_col) >= 32'(n)) begin
            k     <= k + 1'b1;
            state <= S_EADDR;
          end else if (!pass && 32'(e_col) == 32'(i)) begin
            diag      <= e_val;
            have_diag <= 1'b1;
            k         <= k + 1'b1;
            state     <= S_EADDR;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          sigma <= qadd(sigma, qmul(mul_p));
          k     <= k + 1'b1;
          state <= S_EADDR;
        end
        S_REND: begin
          if (!pass) begin
            if (!have_diag || diag == 0) begin
              result <= '{read_value: '0, status: ST_DIAG};
              done   <= 1'b1;
              state  <= S_IDLE;
            end else begin
              state <= S_RB;
            end
          end else begin
            state <= S_TB;
          end
        end
        S_RB: begin
          xi    <= sol_q;
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            qv    <= div_quo;
            state <= S_QM;
          end
        end
        S_QM: begin
          state <= S_QA;
        end
        S_QA: begin
          i     <= i + 1'b1;
          state <= S_RLO;
        end
        // residual pass: r^2 then b^2 through the multiplier
        S_TB: begin
          bv    <= rhs_q;
          state <= S_TR;
        end
        S_TR: begin
          sum_r <= add_r[64] ? '1 : add_r[63:0];
          state <= S_TBB;
        end
        S_TBB: begin
          sum_b <= add_b[64] ? '1 : add_b[63:0];
          i     <= i + 1'b1;
          state <= S_RLO;
        end
        // bound = tol^2 * sum_b / 2^32 from two 32-bit partial products
        S_T2: begin
          state <= S_T2W;
        end
        S_T2W: begin
          t2    <= mul_p[33:0];
          state <= S_B1;
        end
        S_B1: begin
          state <= S_B2;
        end
        S_B2: begin
          p1_hi <= mul_p[63:32];
          state <= S_B3;
        end
        S_B3: begin
          result <= '{read_value: '0, status: ((sum_r <= bound) ? ST_CONV : ST_NOCONV)};
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || $past(start))
    else $error("result without a command in flight");

  a_status_zero_value: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |-> result.read_value == 0)
    else $error("run status with nonzero read value");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_busy)
    else $error("divider restarted while busy");
`endif

endmodule
